FILE: hdl/weighted_queue_sampler_core_assert.svh
// ----------------------------------------------------------------------------
// Weighted queue sampler assertion macros
// Implication and next-cycle checks, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_QUEUE_SAMPLER_CORE_ASSERT_SVH
`define WEIGHTED_QUEUE_SAMPLER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define WQS_ASSERT_IMP(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("wqs assertion failed");
`define WQS_ASSERT_NEXT(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("wqs assertion failed");
`else
`define WQS_ASSERT_IMP(name, clock, reset, ante, cons)
`define WQS_ASSERT_NEXT(name, clock, reset, ante, cons)
`endif

`endif

FILE: hdl/wqs_pkg.sv
// ----------------------------------------------------------------------------
// Weighted queue sampler package
// Sizes, codes and the sum tree node word shared by the sampler files.
// ----------------------------------------------------------------------------
package wqs_pkg;

  localparam int LEAVES      = 64;
  localparam int LEAF_BITS   = $clog2(LEAVES);
  localparam int NODES       = 2 * LEAVES;
  localparam int NODE_BITS   = LEAF_BITS + 1;
  localparam int COUNT_BITS  = 16;
  localparam int TOTAL_BITS  = 22;
  localparam int NE_BITS     = LEAF_BITS + 1;
  localparam int CFG_BITS    = 7;
  localparam int OP_BITS     = 3;
  localparam int STATUS_BITS = 3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX         = {COUNT_BITS{1'b1}};
  localparam logic [CFG_BITS-1:0]   ACTIVE_QUEUES_RST = CFG_BITS'(64);

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD       = 3'd0,
    OP_REMOVE    = 3'd1,
    OP_DRAW_PROP = 3'd2,
    OP_DRAW_UNI  = 3'd3,
    OP_CLEAR     = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_INDEX_BIG = 3'd4,
    ST_BAD_DEST  = 3'd5
  } status_t;

  // One tree node: count sum and non-empty sum (leaves hold count and 0/1).
  typedef struct packed {
    logic [TOTAL_BITS-1:0] cnt;
    logic [NE_BITS-1:0]    ne;
  } node_word_t;

endpackage

FILE: hdl/wqs_cfg_if.sv
// ----------------------------------------------------------------------------
// Weighted queue sampler configuration channel
// Valid/ready write of the active queue count register.
// ----------------------------------------------------------------------------
interface wqs_cfg_if import wqs_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CFG_BITS-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/wqs_cmd_if.sv
// ----------------------------------------------------------------------------
// Weighted queue sampler command channel
// Valid/ready channel carrying one queue operation.
// ----------------------------------------------------------------------------
interface wqs_cmd_if import wqs_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [OP_BITS-1:0]    opcode;
  logic [LEAF_BITS-1:0]  dest;
  logic [TOTAL_BITS-1:0] rand_index;

  modport source (output valid, output opcode, output dest, output rand_index, input ready);
  modport sink (input valid, input opcode, input dest, input rand_index, output ready);
endinterface

FILE: hdl/wqs_rsp_if.sv
// ----------------------------------------------------------------------------
// Weighted queue sampler response channel
// Valid/ready channel carrying one operation result.
// ----------------------------------------------------------------------------
interface wqs_rsp_if import wqs_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [LEAF_BITS-1:0]   chosen;
  logic [STATUS_BITS-1:0] status;
  logic [COUNT_BITS-1:0]  dest_count;
  logic [TOTAL_BITS-1:0]  total_count;

  modport source (output valid, output chosen, output status, output dest_count,
                  output total_count, input ready);
  modport sink (input valid, input chosen, input status, input dest_count,
                input total_count, output ready);
endinterface

FILE: hdl/wqs_ram.sv
// ----------------------------------------------------------------------------
// Weighted queue sampler RAM
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/weighted_queue_sampler_core.sv
// ----------------------------------------------------------------------------
// Weighted queue sampler core
// Packet counts of 64 queues in a sum tree; add, remove, draw and clear.
// ----------------------------------------------------------------------------
// Usage:
//   cmd : one operation per transfer (opcode, dest, rand_index).
//   rsp : one result per operation (chosen, status, dest_count, total_count).
//   cfg : write of the active queue count; ready out of reset, takes effect
//         at once.
// The whole tree (leaves and inner nodes) lives in one heap-ordered RAM,
// index 1 the root, 64..127 the leaves. A small sequencer drives the RAM's
// one read and one write port and the add and compare logic.
// Add/remove reads the leaf, then writes it and walks six parents, one node
// a cycle, to the result. A draw descends six levels, one node a cycle, then
// reads the chosen leaf. Clear, a bad dest, an empty or out-of-range draw and
// unknown opcodes go straight to the result; overflow and underflow stop at
// the leaf. cmd.ready is high only while the sequencer is idle, so a new
// command is taken only once the last result has left the sequencer.
// Reset clears the valid bits of every node (an invalid node reads as zero),
// both totals and the output valid, and sets the active queue count to 64;
// clear does the same to the tree. A stalled receiver holds the result in
// the output register; one more finished result waits in the sequencer.
// ----------------------------------------------------------------------------
`include "weighted_queue_sampler_core_assert.svh"

module weighted_queue_sampler_core import wqs_pkg::*; (
  input logic        clk,
  input logic        rst,
  wqs_cfg_if.sink    cfg,
  wqs_cmd_if.sink    cmd,
  wqs_rsp_if.source  rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEAF,
    S_UP,
    S_DESC,
    S_LEAFRD,
    S_DONE
  } state_t;

  state_t                 state;
  logic [CFG_BITS-1:0]    active_queues;
  logic [TOTAL_BITS-1:0]  count_total;
  logic [NE_BITS-1:0]     ne_total;
  logic [NODE_BITS-1:0]   node;
  logic [TOTAL_BITS-1:0]  idx;
  logic                   is_add;
  logic                   uniform;
  logic                   dne;
  logic [LEAF_BITS-1:0]   res_chosen;
  status_t                res_status;
  logic [COUNT_BITS-1:0]  res_dcount;
  logic [NODES-1:0]       node_valid;
  logic                   rd_vld;

  // RAM ports
  logic                   ram_we;
  logic [NODE_BITS-1:0]   ram_waddr;
  node_word_t             ram_wword;
  logic                   ram_re;
  logic [NODE_BITS-1:0]   ram_raddr;
  logic [$bits(node_word_t)-1:0] ram_rdata;

  // Decoded input and datapath
  logic                   cmd_fire;
  logic                   clear_fire;
  opcode_t                op_in;
  logic                   bad_dest;
  logic [TOTAL_BITS-1:0]  tot_sel;
  node_word_t             word_rd;
  logic [COUNT_BITS-1:0]  leaf_cnt;
  logic                   leaf_err;
  logic [COUNT_BITS-1:0]  leaf_new;
  logic                   leaf_dne;
  logic [TOTAL_BITS-1:0]  ls;
  logic                   go_left;
  logic [NODE_BITS-1:0]   node_step;
  logic                   step_leaf;

  // Refuse every transfer while reset is held.
  assign cfg.ready  = !rst;
  assign cmd.ready  = (state == S_IDLE) && !rst;
  assign cmd_fire   = cmd.valid && cmd.ready;
  assign op_in      = opcode_t'(cmd.opcode);
  assign clear_fire = cmd_fire && (op_in == OP_CLEAR);
  assign bad_dest   = CFG_BITS'(cmd.dest) >= active_queues;
  assign tot_sel    = (op_in == OP_DRAW_UNI) ? TOTAL_BITS'(ne_total) : count_total;

  // A node never written since reset or clear reads as zero.
  assign word_rd  = rd_vld ? node_word_t'(ram_rdata) : '0;
  assign leaf_cnt = word_rd.cnt[COUNT_BITS-1:0];
  assign leaf_err = is_add ? (leaf_cnt == COUNT_MAX) : (leaf_cnt == '0);
  assign leaf_new = is_add ? leaf_cnt + 1'b1 : leaf_cnt - 1'b1;
  assign leaf_dne = is_add ? (leaf_cnt == '0) : (leaf_cnt == COUNT_BITS'(1));

  // Descent step: compare index with the left child's sum, pick a side.
  assign ls        = uniform ? TOTAL_BITS'(word_rd.ne) : word_rd.cnt;
  assign go_left   = idx < ls;
  assign node_step = {node[NODE_BITS-2:0], ~go_left};
  assign step_leaf = node_step[NODE_BITS-1];

  // RAM address and write control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = node;
    ram_wword = '0;
    case (state)
      S_IDLE: begin
        ram_re = cmd_fire;
        if (op_in == OP_ADD || op_in == OP_REMOVE) begin
          ram_raddr = {1'b1, cmd.dest};
        end else begin
          ram_raddr = NODE_BITS'(2);
        end
      end
      S_LEAF: begin
        ram_re        = 1'b1;
        ram_raddr     = node >> 1;
        ram_we        = !leaf_err;
        ram_wword.cnt = TOTAL_BITS'(leaf_new);
        ram_wword.ne  = NE_BITS'(leaf_new != '0);
      end
      S_UP: begin
        ram_re        = (node != NODE_BITS'(1));
        ram_raddr     = node >> 1;
        ram_we        = 1'b1;
        ram_wword.cnt = is_add ? word_rd.cnt + 1'b1 : word_rd.cnt - 1'b1;
        ram_wword.ne  = is_add ? word_rd.ne + NE_BITS'(dne) : word_rd.ne - NE_BITS'(dne);
      end
      S_DESC: begin
        ram_re    = 1'b1;
        ram_raddr = step_leaf ? node_step : {node_step[NODE_BITS-2:0], 1'b0};
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  wqs_ram #(
    .WIDTH ($bits(node_word_t)),
    .DEPTH (NODES)
  ) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wword),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Node valid bits: drop all on reset or clear, mark on write.
  always_ff @(posedge clk) begin
    if (rst || clear_fire) begin
      node_valid <= '0;
    end else if (ram_we) begin
      node_valid[ram_waddr] <= 1'b1;
    end
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (ram_re) begin
      rd_vld <= node_valid[ram_raddr];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rsp.valid     <= 1'b0;
      active_queues <= ACTIVE_QUEUES_RST;
      count_total   <= '0;
      ne_total      <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        active_queues <= cfg.data;
      end
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            is_add     <= (op_in == OP_ADD);
            uniform    <= (op_in == OP_DRAW_UNI);
            idx        <= cmd.rand_index;
            res_chosen <= '0;
            res_status <= ST_OK;
            res_dcount <= '0;
            case (op_in)
              OP_ADD, OP_REMOVE: begin
                node <= {1'b1, cmd.dest};
                if (bad_dest) begin
                  res_status <= ST_BAD_DEST;
                  state      <= S_DONE;
                end else begin
                  state <= S_LEAF;
                end
              end
              OP_DRAW_PROP, OP_DRAW_UNI: begin
                node <= NODE_BITS'(1);
                if (tot_sel == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_DONE;
                end else if (cmd.rand_index >= tot_sel) begin
                  res_status <= ST_INDEX_BIG;
                  state      <= S_DONE;
                end else begin
                  state <= S_DESC;
                end
              end
              OP_CLEAR: begin
                count_total <= '0;
                ne_total    <= '0;
                state       <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_LEAF: begin
          // Update the leaf, or flag and drop the operation.
          res_dcount <= leaf_err ? leaf_cnt : leaf_new;
          if (leaf_err) begin
            res_status <= is_add ? ST_OVERFLOW : ST_UNDERFLOW;
            state      <= S_DONE;
          end else begin
            count_total <= is_add ? count_total + 1'b1 : count_total - 1'b1;
            ne_total    <= is_add ? ne_total + NE_BITS'(leaf_dne)
                                  : ne_total - NE_BITS'(leaf_dne);
            dne         <= leaf_dne;
            node        <= node >> 1;
            state       <= S_UP;
          end
        end
        S_UP: begin
          // Advance one level towards the root per cycle.
          node <= node >> 1;
          if (node == NODE_BITS'(1)) begin
            state <= S_DONE;
          end
        end
        S_DESC: begin
          if (!go_left) begin
            idx <= idx - ls;
          end
          node <= node_step;
          if (step_leaf) begin
            res_chosen <= node_step[LEAF_BITS-1:0];
            state      <= S_LEAFRD;
          end
        end
        S_LEAFRD: begin
          res_dcount <= leaf_cnt;
          state      <= S_DONE;
        end
        S_DONE: begin
          // Hold the result until the output register is free.
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.chosen      <= res_chosen;
            rsp.status      <= res_status;
            rsp.dest_count  <= res_dcount;
            rsp.total_count <= count_total;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Both totals are zero together: a queue with packets is a non-empty queue.
  `WQS_ASSERT_IMP(a_totals_agree, clk, rst, 1'b1, (ne_total == '0) == (count_total == '0))
  // Clear empties the totals by the next cycle.
  `WQS_ASSERT_NEXT(a_clear_totals, clk, rst, clear_fire, count_total == '0 && ne_total == '0)
  // A failed operation never names a queue.
  `WQS_ASSERT_IMP(a_fail_no_choice, clk, rst, rsp.valid && rsp.status != ST_OK, rsp.chosen == '0)

endmodule
